[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, parser phases, register indexes, and the structs that
// pass between the step logic and the top level.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int unsigned COLS     = 80;
    localparam int unsigned ROWS     = 25;
    localparam int unsigned TAB_STEP = 8;

    localparam logic [7:0] RESET_ATTR = 8'h0F;

    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_CR  = 8'd13;
    localparam logic [7:0] BYTE_TAB = 8'd9;

    // Configuration register indexes
    localparam logic [2:0] CFG_ESCAPE = 3'd0;
    localparam logic [2:0] CFG_CLEAR  = 3'd1;
    localparam logic [2:0] CFG_COLOR  = 3'd2;
    localparam logic [2:0] CFG_COLUMN = 3'd3;
    localparam logic [2:0] CFG_ROW    = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_ARG_COLOR,
        PH_ARG_COL,
        PH_ARG_ROW
    } t_phase;

    typedef struct packed {
        logic [7:0] escape_code;
        logic [7:0] clear_code;
        logic [7:0] color_code;
        logic [7:0] column_code;
        logic [7:0] row_code;
    } t_codes;

    typedef struct packed {
        logic [6:0] column;
        logic [4:0] row;
        logic [7:0] attr;
    } t_cursor;

    typedef struct packed {
        logic        cell_write;
        logic [10:0] cell_index;
        logic [7:0]  glyph;
        logic [7:0]  attribute;
        logic        clear_request;
        logic        counted_text;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_row;
    } t_result;

endpackage

[rtl/tcw_step.sv]
// ----------------------------------------------------------------------------
// tcw_step: escape parser and cursor update for one byte
// Pure combinational logic: from the current parser phase, cursor and colour
// it forms the next phase, the next cursor state and the result of the item.
// ----------------------------------------------------------------------------
module tcw_step
    import tcw_pkg::*;
(
    input  t_phase     i_phase,
    input  t_cursor    i_cur,
    input  t_codes     i_codes,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_of_buffer,
    output t_phase     o_phase,
    output t_cursor    o_cur,
    output t_result    o_result
);

    logic [10:0] cell_idx;
    logic        on_screen;
    logic [7:0]  tab_col;

    // row * 80 = row * 64 + row * 16
    assign cell_idx  = {4'd0, i_cur.column}
                     + {i_cur.row, 6'd0}
                     + {2'd0, i_cur.row, 4'd0};
    assign on_screen = (i_cur.row < 5'(ROWS));
    assign tab_col   = {1'b0, i_cur.column} + 8'(TAB_STEP);

    // Next parser phase
    always_comb begin
        o_phase = PH_IDLE;
        case (i_phase)
            PH_IDLE: begin
                if (i_data_byte == i_codes.escape_code) begin
                    o_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (i_data_byte == i_codes.clear_code) begin
                    o_phase = PH_IDLE;
                end else if (i_data_byte == i_codes.color_code) begin
                    o_phase = PH_ARG_COLOR;
                end else if (i_data_byte == i_codes.column_code) begin
                    o_phase = PH_ARG_COL;
                end else if (i_data_byte == i_codes.row_code) begin
                    o_phase = PH_ARG_ROW;
                end
            end
            default: o_phase = PH_IDLE;
        endcase
        // A sequence cut off at the end of a write is dropped.
        if (i_last_of_buffer) begin
            o_phase = PH_IDLE;
        end
    end

    // Cursor, colour and result
    always_comb begin
        o_cur    = i_cur;
        o_result = '0;
        case (i_phase)
            PH_IDLE: begin
                if (i_data_byte != i_codes.escape_code) begin
                    o_result.counted_text = 1'b1;
                    if (on_screen) begin
                        if (i_data_byte == BYTE_LF) begin
                            o_cur.row    = i_cur.row + 5'd1;
                            o_cur.column = '0;
                        end else if (i_data_byte == BYTE_CR) begin
                            o_cur.column = '0;
                        end else if (i_data_byte == BYTE_TAB) begin
                            if (tab_col > 8'(COLS - 1)) begin
                                o_cur.row    = i_cur.row + 5'd1;
                                o_cur.column = 7'(tab_col - 8'(COLS));
                            end else begin
                                o_cur.column = tab_col[6:0];
                            end
                        end else begin
                            o_result.cell_write = 1'b1;
                            o_result.cell_index = cell_idx;
                            o_result.glyph      = i_data_byte;
                            o_result.attribute  = i_cur.attr;
                            if (i_cur.column == 7'(COLS - 1)) begin
                                o_cur.column = '0;
                                o_cur.row    = i_cur.row + 5'd1;
                            end else begin
                                o_cur.column = i_cur.column + 7'd1;
                            end
                        end
                    end
                end
            end
            PH_CMD: begin
                if (i_data_byte == i_codes.clear_code) begin
                    o_cur.column           = '0;
                    o_cur.row              = '0;
                    o_cur.attr             = RESET_ATTR;
                    o_result.clear_request = 1'b1;
                end
            end
            PH_ARG_COLOR: begin
                o_cur.attr = i_data_byte;
            end
            PH_ARG_COL: begin
                if (i_data_byte < 8'(COLS)) begin
                    o_cur.column = i_data_byte[6:0];
                end
            end
            PH_ARG_ROW: begin
                if (i_data_byte < 8'(ROWS)) begin
                    o_cur.row = i_data_byte[4:0];
                end
            end
            default: begin
                o_cur = i_cur;
            end
        endcase
        o_result.cursor_column = o_cur.column;
        o_result.cursor_row    = o_cur.row;
    end

endmodule

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top: 80x25 text console writer
// A result is registered in the output stage as its byte is accepted.
// Throughput: one byte per cycle while the skid entry is empty; the cursor
// and parser update is one registered pass, and a two-entry output stage
// absorbs a stall. Reset (synchronous, active low): cursor 0,0, colour 0x0F,
// parser idle, command codes to their defaults, output stage empty.
// ----------------------------------------------------------------------------
module text_console_writer_top
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_buffer,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_cell_write,
    output logic [10:0] o_cell_index,
    output logic [7:0]  o_glyph,
    output logic [7:0]  o_attribute,
    output logic        o_clear_request,
    output logic        o_counted_text,
    output logic [6:0]  o_cursor_column,
    output logic [4:0]  o_cursor_row
);

    t_codes  r_codes;
    t_cursor r_cur;
    t_phase  r_phase;
    t_cursor n_cur;
    t_phase  n_phase;
    t_result n_result;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    logic in_acc;
    logic out_take;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid & ~r_skid_valid;
    assign out_take = r_out_valid & ~i_stall;

    tcw_step u_step (
        .i_phase          (r_phase),
        .i_cur            (r_cur),
        .i_codes          (r_codes),
        .i_data_byte      (i_data_byte),
        .i_last_of_buffer (i_last_of_buffer),
        .o_phase          (n_phase),
        .o_cur            (n_cur),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.escape_code <= 8'd27;
            r_codes.clear_code  <= 8'd67;
            r_codes.color_code  <= 8'd75;
            r_codes.column_code <= 8'd88;
            r_codes.row_code    <= 8'd89;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ESCAPE: r_codes.escape_code <= i_cfg_data;
                CFG_CLEAR:  r_codes.clear_code  <= i_cfg_data;
                CFG_COLOR:  r_codes.color_code  <= i_cfg_data;
                CFG_COLUMN: r_codes.column_code <= i_cfg_data;
                CFG_ROW:    r_codes.row_code    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur.column <= '0;
            r_cur.row    <= '0;
            r_cur.attr   <= RESET_ATTR;
            r_phase      <= PH_IDLE;
        end else if (in_acc) begin
            r_cur   <= n_cur;
            r_phase <= n_phase;
        end
    end

    // Output register with a skid entry behind it. The skid only fills when
    // an item arrives while the output register is held by a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_take) begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_write    = r_out.cell_write;
    assign o_cell_index    = r_out.cell_index;
    assign o_glyph         = r_out.glyph;
    assign o_attribute     = r_out.attribute;
    assign o_clear_request = r_out.clear_request;
    assign o_counted_text  = r_out.counted_text;
    assign o_cursor_column = r_out.cursor_column;
    assign o_cursor_row    = r_out.cursor_row;

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register is empty");

    // The cursor never leaves the screen except one row past the bottom.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.column < 7'(COLS)) && (r_cur.row <= 5'(ROWS)))
        else $error("cursor out of range");

    // A byte that ends a write always leaves the parser idle.
    a_last_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_of_buffer) |=> (r_phase == PH_IDLE))
        else $error("parser not idle after last byte of a write");

    // A cell write lies on screen and never comes with a clear.
    a_write_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.cell_write) |->
            (!r_out.clear_request && r_out.counted_text
             && (r_out.cell_index < 11'(COLS * ROWS))))
        else $error("inconsistent cell write result");

endmodule

[tb/tb_text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// tb_text_console_writer_top: self-checking bench for the text console writer
// A driver feeds console bytes from a queue and a monitor checks every
// result against a cycle-free model of the cursor, colour and escape parser.
// A directed opening is followed by random writes under several sets of
// command codes and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
    import tcw_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_console_byte;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte   = 8'd0;
    logic        in_last   = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_cell_write;
    logic [10:0] out_cell_index;
    logic [7:0]  out_glyph;
    logic [7:0]  out_attribute;
    logic        out_clear_request;
    logic        out_counted_text;
    logic [6:0]  out_cursor_column;
    logic [4:0]  out_cursor_row;

    text_console_writer_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_data_byte      (in_byte),
        .i_last_of_buffer (in_last),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_cell_write     (out_cell_write),
        .o_cell_index     (out_cell_index),
        .o_glyph          (out_glyph),
        .o_attribute      (out_attribute),
        .o_clear_request  (out_clear_request),
        .o_counted_text   (out_counted_text),
        .o_cursor_column  (out_cursor_column),
        .o_cursor_row     (out_cursor_row)
    );

    initial forever #2 clk = ~clk;

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Console state as the block should hold it.
    t_codes     mdl_codes;
    logic [6:0] mdl_col;
    logic [4:0] mdl_row;
    logic [7:0] mdl_attr;
    t_phase     mdl_phase;

    t_console_byte byte_queue[$];
    t_result       expected_cells[$];
    t_console_byte next_byte;
    t_result       seen;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int err_count = 0;
    int bytes_queued = 0;

    function automatic t_result console_step(input logic [7:0] b, input logic last);
        t_result     r;
        int unsigned cell_num;
        int unsigned tab_col;
        r = '0;
        case (mdl_phase)
            PH_IDLE: begin
                if (b == mdl_codes.escape_code) begin
                    mdl_phase = last ? PH_IDLE : PH_CMD;
                end else begin
                    r.counted_text = 1'b1;
                    cell_num = mdl_col + mdl_row * COLS;
                    // Past the last cell nothing moves and nothing is written.
                    if (cell_num < COLS * ROWS) begin
                        if (b == BYTE_LF) begin
                            mdl_row = mdl_row + 5'd1;
                            mdl_col = 7'd0;
                        end else if (b == BYTE_CR) begin
                            mdl_col = 7'd0;
                        end else if (b == BYTE_TAB) begin
                            tab_col = mdl_col + TAB_STEP;
                            if (tab_col > COLS - 1) mdl_row = mdl_row + 5'd1;
                            mdl_col = 7'(tab_col % COLS);
                        end else begin
                            r.cell_write = 1'b1;
                            r.cell_index = cell_num[10:0];
                            r.glyph      = b;
                            r.attribute  = mdl_attr;
                            if (mdl_col == COLS - 1) begin
                                mdl_col = 7'd0;
                                mdl_row = mdl_row + 5'd1;
                            end else begin
                                mdl_col = mdl_col + 7'd1;
                            end
                        end
                    end
                end
            end
            PH_CMD: begin
                mdl_phase = PH_IDLE;
                if (b == mdl_codes.clear_code) begin
                    mdl_col = 7'd0;
                    mdl_row = 5'd0;
                    mdl_attr = RESET_ATTR;
                    r.clear_request = 1'b1;
                end else if (b == mdl_codes.color_code) begin
                    if (!last) mdl_phase = PH_ARG_COLOR;
                end else if (b == mdl_codes.column_code) begin
                    if (!last) mdl_phase = PH_ARG_COL;
                end else if (b == mdl_codes.row_code) begin
                    if (!last) mdl_phase = PH_ARG_ROW;
                end
            end
            PH_ARG_COLOR: begin
                mdl_attr = b;
                mdl_phase = PH_IDLE;
            end
            PH_ARG_COL: begin
                if (b < COLS) mdl_col = b[6:0];
                mdl_phase = PH_IDLE;
            end
            PH_ARG_ROW: begin
                if (b < ROWS) mdl_row = b[4:0];
                mdl_phase = PH_IDLE;
            end
            default: begin
                mdl_phase = PH_IDLE;
            end
        endcase
        if (last) mdl_phase = PH_IDLE;
        r.cursor_column = mdl_col;
        r.cursor_row = mdl_row;
        return r;
    endfunction

    // Driver: presents queued bytes, holding each one while the block stalls.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_cells.push_back(console_step(in_byte, in_last));
            end
            if (!in_valid || !in_stall) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_byte = byte_queue.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= next_byte.data;
                    in_last <= next_byte.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            err_count++;
        end
    endtask

    // Monitor: stalls at random and checks each accepted result in order.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_cells.size() == 0) begin
                    $error("result with no item waiting for it");
                    err_count++;
                end else begin
                    seen = expected_cells.pop_front();
                    check_field("cell_write", 32'(seen.cell_write),
                                32'(out_cell_write));
                    check_field("cell_index", 32'(seen.cell_index),
                                32'(out_cell_index));
                    check_field("glyph", 32'(seen.glyph), 32'(out_glyph));
                    check_field("attribute", 32'(seen.attribute),
                                32'(out_attribute));
                    check_field("clear_request", 32'(seen.clear_request),
                                32'(out_clear_request));
                    check_field("counted_text", 32'(seen.counted_text),
                                32'(out_counted_text));
                    check_field("cursor_column", 32'(seen.cursor_column),
                                32'(out_cursor_column));
                    check_field("cursor_row", 32'(seen.cursor_row),
                                32'(out_cursor_row));
                end
            end
            out_stall <= ($urandom_range(99) < snk_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_console_byte item;
        item.data = b;
        item.last = last;
        byte_queue.push_back(item);
        bytes_queued++;
    endtask

    // Returns once every queued item has been taken and answered.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || expected_cells.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_ESCAPE: mdl_codes.escape_code = val;
            CFG_CLEAR:  mdl_codes.clear_code = val;
            CFG_COLOR:  mdl_codes.color_code = val;
            CFG_COLUMN: mdl_codes.column_code = val;
            CFG_ROW:    mdl_codes.row_code = val;
            default: ;
        endcase
    endtask

    task automatic load_codes(input logic [7:0] esc, input logic [7:0] clr,
                              input logic [7:0] clrr, input logic [7:0] col,
                              input logic [7:0] row);
        write_reg(CFG_ESCAPE, esc);
        write_reg(CFG_CLEAR, clr);
        write_reg(CFG_COLOR, clrr);
        write_reg(CFG_COLUMN, col);
        write_reg(CFG_ROW, row);
        cfg_we <= 1'b0;
    endtask

    // One console write: a few tokens, mostly well-formed, the last byte marked.
    task automatic add_write();
        logic [7:0] seq[$];
        int         tokens;
        int         pick;
        int         cut;
        tokens = $urandom_range(8, 1);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 34) begin
                seq.push_back(8'($urandom_range(255)));
            end else if (pick < 40) begin
                seq.push_back(8'($urandom_range(126, 32)));
            end else if (pick < 50) begin
                case ($urandom_range(2))
                    0: seq.push_back(BYTE_LF);
                    1: seq.push_back(BYTE_CR);
                    default: seq.push_back(BYTE_TAB);
                endcase
            end else if (pick < 62) begin
                seq.push_back(mdl_codes.escape_code);
                seq.push_back(mdl_codes.column_code);
                seq.push_back(($urandom_range(4) != 0) ? 8'($urandom_range(79))
                                                       : 8'($urandom_range(255)));
            end else if (pick < 74) begin
                seq.push_back(mdl_codes.escape_code);
                seq.push_back(mdl_codes.row_code);
                seq.push_back(($urandom_range(4) != 0) ? 8'($urandom_range(24))
                                                       : 8'($urandom_range(255)));
            end else if (pick < 82) begin
                seq.push_back(mdl_codes.escape_code);
                seq.push_back(mdl_codes.color_code);
                seq.push_back(8'($urandom_range(255)));
            end else if (pick < 86) begin
                seq.push_back(mdl_codes.escape_code);
                seq.push_back(mdl_codes.clear_code);
            end else if (pick < 95) begin
                // A bare escape or one with a random command byte.
                seq.push_back(mdl_codes.escape_code);
                if (pick < 91) seq.push_back(8'($urandom_range(255)));
            end else begin
                seq.push_back(mdl_codes.escape_code);
                seq.push_back(8'($urandom_range(255)));
                seq.push_back(8'($urandom_range(255)));
            end
        end
        // Some writes end early, often in the middle of a sequence.
        if ($urandom_range(99) < 12) begin
            cut = $urandom_range(seq.size(), 1);
            while (seq.size() > cut) void'(seq.pop_back());
        end
        foreach (seq[i]) push_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int budget);
        int target;
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        target = bytes_queued + budget;
        while (bytes_queued < target) add_write();
        wait_drained();
    endtask

    initial begin
        mdl_codes = '{escape_code: 8'd27, clear_code: 8'd67, color_code: 8'd75,
                      column_code: 8'd88, row_code: 8'd89};
        mdl_col = 7'd0;
        mdl_row = 5'd0;
        mdl_attr = RESET_ATTR;
        mdl_phase = PH_IDLE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset codes.
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.column_code, 1'b0);
        push_byte(8'd80, 1'b0);                 // column out of range, ignored
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.row_code, 1'b0);
        push_byte(8'd24, 1'b0);
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.column_code, 1'b0);
        push_byte(8'd76, 1'b0);
        push_byte(BYTE_TAB, 1'b0);              // wraps and leaves the screen
        push_byte(8'hFF, 1'b0);                 // past the last cell: no write
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.clear_code, 1'b1);  // a clear still works when cut off
        push_byte(8'h00, 1'b0);
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.color_code, 1'b0);
        push_byte(mdl_codes.escape_code, 1'b0); // escape taken as the colour
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(8'h51, 1'b0);                 // unknown command
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.color_code, 1'b1);  // colour command cut off
        push_byte(mdl_codes.escape_code, 1'b1); // escape cut off
        push_byte(BYTE_CR, 1'b0);
        push_byte(BYTE_LF, 1'b0);
        push_byte(mdl_codes.escape_code, 1'b0);
        push_byte(mdl_codes.row_code, 1'b0);
        push_byte(8'd25, 1'b1);                 // row out of range, ignored
        wait_drained();

        run_phase(0, 0, 270);

        load_codes(8'h00, 8'hFF, 8'h00, 8'hFE, 8'h01);
        for (int k = 1; k <= 3; k++) write_reg(CFG_ROW + 3'(k), 8'($urandom_range(255)));
        cfg_we <= 1'b0;
        run_phase(55, 0, 270);

        load_codes(8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h80);
        run_phase(0, 55, 270);

        // All commands share one code, so the clear must win.
        begin
            logic [7:0] shared;
            shared = 8'($urandom_range(255));
            load_codes(8'($urandom_range(255)), shared, shared, shared, shared);
        end
        run_phase(32, 32, 270);

        load_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
        run_phase(0, 0, 135);
        run_phase(0, 0, 135);

        begin
            logic [7:0] shared;
            shared = 8'($urandom_range(255));
            load_codes(8'($urandom_range(255)), ~shared, shared, shared, shared);
        end
        run_phase(32, 32, 270);

        wait_drained();
        if (expected_cells.size() != 0) begin
            $error("%0d results never arrived", expected_cells.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
